[rtl/core/aet_pkg.sv]
`default_nettype none
package aet_pkg;

  localparam int NUM_BITS_DEF   = 16;
  localparam int HOLD_DEPTH_DEF = 4;
  localparam int TOK_W          = 5;
  localparam int CHR_W          = 8;
  localparam int ARG_W          = 16;

  localparam logic [TOK_W-1:0] TOK_PLAIN = 5'd0;
  localparam logic [TOK_W-1:0] TOK_BS    = 5'd1;
  localparam logic [TOK_W-1:0] TOK_CE    = 5'd2;
  localparam logic [TOK_W-1:0] TOK_CL    = 5'd3;
  localparam logic [TOK_W-1:0] TOK_CM    = 5'd4;
  localparam logic [TOK_W-1:0] TOK_CR    = 5'd5;
  localparam logic [TOK_W-1:0] TOK_ER    = 5'd6;
  localparam logic [TOK_W-1:0] TOK_LF    = 5'd7;
  localparam logic [TOK_W-1:0] TOK_ND    = 5'd8;
  localparam logic [TOK_W-1:0] TOK_SE    = 5'd9;
  localparam logic [TOK_W-1:0] TOK_SO    = 5'd10;
  localparam logic [TOK_W-1:0] TOK_TA    = 5'd11;
  localparam logic [TOK_W-1:0] TOK_UP    = 5'd12;
  localparam logic [TOK_W-1:0] TOK_HM    = 5'd13;
  localparam logic [TOK_W-1:0] TOK_CH    = 5'd14;
  localparam logic [TOK_W-1:0] TOK_NU    = 5'd15;
  localparam logic [TOK_W-1:0] TOK_NR    = 5'd16;
  localparam logic [TOK_W-1:0] TOK_NL    = 5'd17;
  localparam logic [TOK_W-1:0] TOK_SC    = 5'd18;
  localparam logic [TOK_W-1:0] TOK_RC    = 5'd19;
  localparam logic [TOK_W-1:0] TOK_SR    = 5'd20;
  localparam logic [TOK_W-1:0] TOK_CB    = 5'd21;

  typedef struct packed {
    logic load;
    logic step;
    logic direct;
    logic flush;
  } aet_cmd_t;

  typedef struct packed {
    logic q_empty;
    logic q_last;
    logic res_v;
    logic pend_v;
    logic out_free;
  } aet_stat_t;

  typedef struct packed {
    logic [TOK_W-1:0] token;
    logic [CHR_W-1:0] chr;
    logic [ARG_W-1:0] a1;
    logic [ARG_W-1:0] a2;
  } aet_res_t;

endpackage
`default_nettype wire

[rtl/core/ansi_escape_tokenizer_core.sv]
`default_nettype none
// Channel   Direction  Ports                                        Handshake
// input     in         in_byte_in                                   in_valid / in_ready
// result    out        out_token out_char_value out_arg_one         out_valid / out_ready
//                      out_arg_two out_last
//
// A byte is taken in idle, then the replay queue is worked one byte per cycle
// unless a stalled output holds it. A plain byte with a free output goes straight
// out; a failed lookahead replays bytes, and a last pending word is flushed.
// Reset (rst_n low, synchronous) returns the parser to idle with no held bytes.
// A word bound for a stalled output holds the controller until the output frees.
module ansi_escape_tokenizer_core
  import aet_pkg::*;
#(
  parameter int NUM_BITS   = NUM_BITS_DEF,
  parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [CHR_W-1:0] in_byte_in,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [TOK_W-1:0]      out_token,
  output logic [CHR_W-1:0]      out_char_value,
  output logic [ARG_W-1:0]      out_arg_one,
  output logic [ARG_W-1:0]      out_arg_two,
  output logic                  out_last
);

  aet_cmd_t  cmd;
  aet_stat_t stat;

  // sequencer: accept, step the queue, flush the final word
  aet_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // parser state, replay queue, held bytes, pending and output words
  aet_dpath #(
    .NUM_BITS   (NUM_BITS),
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .byte_in        (in_byte_in),
    .cmd            (cmd),
    .stat           (stat),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_token      (out_token),
    .out_char_value (out_char_value),
    .out_arg_one    (out_arg_one),
    .out_arg_two    (out_arg_two),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire

[rtl/core/aet_ctrl.sv]
`default_nettype none
module aet_ctrl
  import aet_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire aet_stat_t stat,
  output aet_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        // hold while a result must push the pending word into a full output
        if (!(stat.res_v && stat.pend_v && !stat.out_free)) begin
          cmd.step = 1'b1;
          if (stat.q_last) begin
            if (stat.res_v) begin
              if (!stat.pend_v && stat.out_free) begin
                cmd.direct = 1'b1;
                state_nxt  = S_IDLE;
              end else begin
                state_nxt = S_FLUSH;
              end
            end else if (stat.pend_v) begin
              state_nxt = S_FLUSH;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !stat.pend_v) else $error("pending word left in idle");
  a_flush_has_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH) |-> stat.pend_v) else $error("flush without pending word");
  a_run_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> !stat.q_empty) else $error("run with empty byte queue");

endmodule
`default_nettype wire

[rtl/core/aet_dpath.sv]
`default_nettype none
module aet_dpath
  import aet_pkg::*;
#(
  parameter int NUM_BITS   = NUM_BITS_DEF,
  parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [CHR_W-1:0] byte_in,
  input  wire aet_cmd_t         cmd,
  output aet_stat_t             stat,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic [TOK_W-1:0]      out_token,
  output logic [CHR_W-1:0]      out_char_value,
  output logic [ARG_W-1:0]      out_arg_one,
  output logic [ARG_W-1:0]      out_arg_two,
  output logic                  out_last
);

  localparam int QCAP = 2 * HOLD_DEPTH + 2;
  localparam int QLW  = $clog2(QCAP + 1);
  localparam int HCW  = $clog2(HOLD_DEPTH + 1);
  localparam int HIW  = $clog2(HOLD_DEPTH);
  localparam int RNW  = $clog2(HOLD_DEPTH + 2);
  localparam int PW   = NUM_BITS + 4;

  localparam logic [3:0] P_IDLE     = 4'd0;
  localparam logic [3:0] P_ESC      = 4'd1;
  localparam logic [3:0] P_CSI      = 4'd2;
  localparam logic [3:0] P_Q        = 4'd3;
  localparam logic [3:0] P_LK_H     = 4'd4;
  localparam logic [3:0] P_LK_PAREN = 4'd5;
  localparam logic [3:0] P_LK_Q7    = 4'd6;
  localparam logic [3:0] P_LK_Q1H   = 4'd7;
  localparam logic [3:0] P_LK_Q1L   = 4'd8;
  localparam logic [3:0] P_NUM1     = 4'd9;
  localparam logic [3:0] P_SEMI1    = 4'd10;
  localparam logic [3:0] P_NUM2     = 4'd11;
  localparam logic [3:0] P_SEMI2    = 4'd12;
  localparam logic [3:0] P_NUM3     = 4'd13;
  localparam logic [3:0] P_SWALLOW  = 4'd14;

  localparam logic [7:0] C_ESC   = 8'h1B;
  localparam logic [7:0] C_SI    = 8'h0F;
  localparam logic [7:0] C_BS    = 8'h08;
  localparam logic [7:0] C_LF    = 8'h0A;
  localparam logic [7:0] C_CR    = 8'h0D;
  localparam logic [7:0] C_TAB   = 8'h09;
  localparam logic [7:0] C_LBR   = 8'h5B;
  localparam logic [7:0] C_LPAR  = 8'h28;
  localparam logic [7:0] C_RPAR  = 8'h29;
  localparam logic [7:0] C_QM    = 8'h3F;
  localparam logic [7:0] C_SEMI  = 8'h3B;
  localparam logic [7:0] C_EQ    = 8'h3D;
  localparam logic [7:0] C_GT    = 8'h3E;
  localparam logic [7:0] C_D0    = 8'h30;
  localparam logic [7:0] C_D1    = 8'h31;
  localparam logic [7:0] C_D7    = 8'h37;
  localparam logic [7:0] C_D8    = 8'h38;
  localparam logic [7:0] C_D9    = 8'h39;
  localparam logic [7:0] C_UA    = 8'h41;
  localparam logic [7:0] C_UB    = 8'h42;
  localparam logic [7:0] C_UC    = 8'h43;
  localparam logic [7:0] C_UD    = 8'h44;
  localparam logic [7:0] C_UH    = 8'h48;
  localparam logic [7:0] C_UJ    = 8'h4A;
  localparam logic [7:0] C_UK    = 8'h4B;
  localparam logic [7:0] C_UM    = 8'h4D;
  localparam logic [7:0] C_LH    = 8'h68;
  localparam logic [7:0] C_LL    = 8'h6C;
  localparam logic [7:0] C_LM    = 8'h6D;
  localparam logic [7:0] C_LR    = 8'h72;

  function automatic logic [2:0] pat_len(input logic [3:0] s);
    case (s)
      P_LK_H:  pat_len = 3'd3;
      P_LK_Q7: pat_len = 3'd2;
      default: pat_len = 3'd4;
    endcase
  endfunction

  function automatic logic [7:0] pat_byte(input logic [3:0] s, input logic [1:0] i);
    logic [7:0] r;
    r = C_ESC;
    case (s)
      P_LK_H: begin
        case (i)
          2'd0:    r = C_ESC;
          2'd1:    r = C_LBR;
          default: r = C_UJ;
        endcase
      end
      P_LK_PAREN: begin
        case (i)
          2'd0:    r = C_UB;
          2'd1:    r = C_ESC;
          2'd2:    r = C_RPAR;
          default: r = C_D0;
        endcase
      end
      P_LK_Q7: r = (i == 2'd0) ? C_D7 : C_LH;
      P_LK_Q1H: begin
        case (i)
          2'd0:    r = C_D1;
          2'd1:    r = C_LH;
          2'd2:    r = C_ESC;
          default: r = C_EQ;
        endcase
      end
      default: begin
        case (i)
          2'd0:    r = C_D1;
          2'd1:    r = C_LL;
          2'd2:    r = C_ESC;
          default: r = C_GT;
        endcase
      end
    endcase
    pat_byte = r;
  endfunction

  function automatic logic [NUM_BITS-1:0] accum(input logic [NUM_BITS-1:0] v,
                                                input logic [3:0] d);
    logic [PW-1:0] p;
    p = ({4'b0, v} << 3) + ({4'b0, v} << 1) + PW'(d);
    accum = (p > PW'({NUM_BITS{1'b1}})) ? {NUM_BITS{1'b1}} : p[NUM_BITS-1:0];
  endfunction

  function automatic aet_res_t mk(input logic [TOK_W-1:0] t, input logic [7:0] c,
                                  input logic [ARG_W-1:0] x, input logic [ARG_W-1:0] y);
    aet_res_t r;
    r.token = t;
    r.chr   = c;
    r.a1    = x;
    r.a2    = y;
    mk = r;
  endfunction

  logic [7:0]          q_r [QCAP];
  logic [7:0]          qn [QCAP];
  logic [QLW-1:0]      q_len_r, q_len_nxt;
  logic [3:0]          ps_r, ps_nxt;
  logic [7:0]          held_r [HOLD_DEPTH];
  logic [HCW-1:0]      hc_r, hc_nxt;
  logic [NUM_BITS-1:0] n1_r, n1_nxt, n2_r, n2_nxt;
  aet_res_t            pend_r, out_r, res;
  logic                pend_v_r, out_v_r, out_last_r;

  logic [7:0]          b;
  logic                dig, res_v, hwe, start, match;
  logic [3:0]          dv, ls;
  logic [2:0]          plen;
  logic [HCW-1:0]      hc_inc, m;
  logic [HIW-1:0]      hwi;
  logic [RNW-1:0]      push_n;
  logic [7:0]          rep [HOLD_DEPTH+1];
  logic [ARG_W-1:0]    a1w, a2w;

  assign b   = q_r[0];
  assign dig = b inside {[C_D0:C_D9]};
  assign dv  = 4'(b - C_D0);
  assign a1w = ARG_W'(n1_r);
  assign a2w = ARG_W'(n2_r);

  // one byte of the replay queue per step, at most one result
  always_comb begin
    res_v  = 1'b0;
    res    = '0;
    ps_nxt = ps_r;
    hc_nxt = hc_r;
    n1_nxt = n1_r;
    n2_nxt = n2_r;
    hwe    = 1'b0;
    hwi    = '0;
    push_n = '0;
    start  = 1'b0;
    match  = 1'b0;
    hc_inc = hc_r + HCW'(1);
    m      = '0;
    ls     = (ps_r == P_LK_Q1H && hc_r == HCW'(1) && b == C_LL) ? P_LK_Q1L : ps_r;
    plen   = pat_len(ls);
    for (int i = 0; i <= HOLD_DEPTH; i++) rep[i] = b;
    if (ps_r inside {[P_LK_H:P_LK_Q1L]}) begin
      match = (hc_r < HCW'(plen)) && (b == pat_byte(ls, hc_r[1:0]));
      if (match) begin
        hwe = 1'b1;
        hwi = hc_r[HIW-1:0];
        if (hc_inc == HCW'(plen)) begin
          res_v  = 1'b1;
          res    = mk((ps_r == P_LK_H) ? TOK_CL : TOK_ER, 8'd0, '0, '0);
          ps_nxt = P_IDLE;
          hc_nxt = '0;
        end else begin
          hc_nxt = hc_inc;
          ps_nxt = ls;
        end
      end else begin
        // replay unsent held bytes and the breaking byte before the queue
        res_v = 1'b1;
        if (ps_r == P_LK_H) begin
          res = mk(TOK_HM, 8'd0, '0, '0);
        end else if (ps_r == P_LK_PAREN) begin
          res = mk(TOK_PLAIN, C_LPAR, '0, '0);
        end else begin
          start = 1'b1;
          res   = mk(TOK_PLAIN, (hc_r != '0) ? held_r[0] : 8'd0, '0, '0);
        end
        m = (hc_r > HCW'(start)) ? hc_r - HCW'(start) : '0;
        for (int i = 0; i <= HOLD_DEPTH; i++) begin
          if (HCW'(i) < m) rep[i] = held_r[HIW'(start ? i + 1 : i)];
        end
        push_n = RNW'(m) + RNW'(1);
        ps_nxt = P_IDLE;
        hc_nxt = '0;
      end
    end else begin
      ps_nxt = P_IDLE;
      case (ps_r)
        P_IDLE: begin
          res_v = 1'b1;
          if (b == C_ESC) begin
            res_v  = 1'b0;
            ps_nxt = P_ESC;
          end else if (b == C_SI)  res = mk(TOK_ER, 8'd0, '0, '0);
          else if (b == C_BS)      res = mk(TOK_BS, 8'd0, '0, '0);
          else if (b == C_LF)      res = mk(TOK_LF, 8'd0, '0, '0);
          else if (b == C_CR)      res = mk(TOK_CR, 8'd0, '0, '0);
          else if (b == C_TAB)     res = mk(TOK_TA, 8'd0, '0, '0);
          else                     res = mk(TOK_PLAIN, b, '0, '0);
        end
        P_ESC: begin
          res_v = 1'b1;
          if (b == C_LBR) begin
            res_v  = 1'b0;
            ps_nxt = P_CSI;
          end else if (b == C_LPAR) begin
            res_v  = 1'b0;
            ps_nxt = P_LK_PAREN;
            hc_nxt = '0;
          end else if (b == C_D7) res = mk(TOK_SC, 8'd0, '0, '0);
          else if (b == C_D8)     res = mk(TOK_RC, 8'd0, '0, '0);
          else if (b == C_UM)     res = mk(TOK_SR, 8'd0, '0, '0);
          else                    res = mk(TOK_PLAIN, b, '0, '0);
        end
        P_CSI: begin
          res_v = 1'b1;
          if (b == C_UA)      res = mk(TOK_UP, 8'd0, '0, '0);
          else if (b == C_UH) begin
            res_v  = 1'b0;
            ps_nxt = P_LK_H;
            hc_nxt = '0;
          end else if (b == C_UK) res = mk(TOK_CE, 8'd0, '0, '0);
          else if (b == C_LM)     res = mk(TOK_SE, 8'd0, '0, '0);
          else if (b == C_QM) begin
            res_v  = 1'b0;
            ps_nxt = P_Q;
          end else if (dig) begin
            res_v  = 1'b0;
            n1_nxt = accum('0, dv);
            ps_nxt = P_NUM1;
          end else res = mk(TOK_PLAIN, C_LBR, '0, '0);
        end
        P_Q: begin
          if (b == C_D7 || b == C_D1) begin
            hwe    = 1'b1;
            hwi    = '0;
            hc_nxt = HCW'(1);
            ps_nxt = (b == C_D7) ? P_LK_Q7 : P_LK_Q1H;
          end else begin
            res_v = 1'b1;
            res   = mk(TOK_PLAIN, b, '0, '0);
          end
        end
        P_NUM1: begin
          res_v = 1'b1;
          if (dig) begin
            res_v  = 1'b0;
            n1_nxt = accum(n1_r, dv);
            ps_nxt = P_NUM1;
          end else if (b == C_LM)
            res = mk((n1_r == NUM_BITS'(7)) ? TOK_SO : TOK_ER, 8'd0, '0, '0);
          else if (b == C_UA) res = mk(TOK_NU, 8'd0, a1w, '0);
          else if (b == C_UB) res = mk(TOK_ND, 8'd0, a1w, '0);
          else if (b == C_UC) res = mk(TOK_NR, 8'd0, a1w, '0);
          else if (b == C_UD) res = mk(TOK_NL, 8'd0, a1w, '0);
          else if (b == C_UK)
            res = mk((n1_r == NUM_BITS'(1)) ? TOK_CB : TOK_ER, 8'd0, '0, '0);
          else if (b == C_SEMI) begin
            res_v  = 1'b0;
            ps_nxt = P_SEMI1;
          end else res = mk(TOK_PLAIN, C_LBR, '0, '0);
        end
        P_SEMI1: begin
          if (dig) begin
            n2_nxt = accum('0, dv);
            ps_nxt = P_NUM2;
          end else begin
            res_v = 1'b1;
            res   = mk(TOK_PLAIN, C_LBR, '0, '0);
          end
        end
        P_NUM2: begin
          res_v = 1'b1;
          if (dig) begin
            res_v  = 1'b0;
            n2_nxt = accum(n2_r, dv);
            ps_nxt = P_NUM2;
          end else if (b == C_UH) res = mk(TOK_CM, 8'd0, a1w, a2w);
          else if (b == C_LR)     res = mk(TOK_CH, 8'd0, a1w, a2w);
          else if (b == C_SEMI) begin
            res_v  = 1'b0;
            ps_nxt = P_SEMI2;
          end else res = mk(TOK_PLAIN, C_LBR, '0, '0);
        end
        P_SEMI2: begin
          if (dig) ps_nxt = P_NUM3;
          else begin
            res_v = 1'b1;
            res   = mk(TOK_PLAIN, C_LBR, '0, '0);
          end
        end
        P_NUM3: begin
          if (dig) ps_nxt = P_NUM3;
          else if (b == C_LM) ps_nxt = P_SWALLOW;
          else begin
            res_v = 1'b1;
            res   = mk(TOK_PLAIN, C_LBR, '0, '0);
          end
        end
        P_SWALLOW: begin
          res_v = 1'b1;
          res   = mk(TOK_ER, 8'd0, '0, '0);
        end
        default: hc_nxt = '0;
      endcase
    end
  end

  // drop the head, put replayed bytes in front of the rest
  always_comb begin
    for (int i = 0; i < QCAP; i++) begin
      qn[i] = 8'd0;
      for (int k = 0; k <= HOLD_DEPTH + 1; k++) begin
        if (push_n == RNW'(k)) begin
          if (i < k) qn[i] = rep[(i <= HOLD_DEPTH) ? i : 0];
          else if (i - k + 1 < QCAP) qn[i] = q_r[(i - k + 1 < QCAP) ? i - k + 1 : 0];
        end
      end
    end
    q_len_nxt = q_len_r - QLW'(1) + QLW'(push_n);
  end

  assign stat.q_empty  = (q_len_r == '0);
  assign stat.q_last   = (q_len_nxt == '0);
  assign stat.res_v    = res_v;
  assign stat.pend_v   = pend_v_r;
  assign stat.out_free = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) q_r[0] <= byte_in;
    if (cmd.step) begin
      for (int i = 0; i < QCAP; i++) q_r[i] <= qn[i];
      if (hwe) held_r[hwi] <= b;
    end
    if (cmd.step && res_v) begin
      if (cmd.direct) begin
        out_r      <= res;
        out_last_r <= 1'b1;
      end else begin
        pend_r <= res;
        if (pend_v_r) begin
          out_r      <= pend_r;
          out_last_r <= 1'b0;
        end
      end
    end
    if (cmd.flush) begin
      out_r      <= pend_r;
      out_last_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_len_r  <= '0;
      ps_r     <= P_IDLE;
      hc_r     <= '0;
      n1_r     <= '0;
      n2_r     <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cmd.load) q_len_r <= QLW'(1);
      if (cmd.step) begin
        q_len_r <= q_len_nxt;
        ps_r    <= ps_nxt;
        hc_r    <= hc_nxt;
        n1_r    <= n1_nxt;
        n2_r    <= n2_nxt;
        if (res_v && !cmd.direct) pend_v_r <= 1'b1;
      end
      if (cmd.flush) pend_v_r <= 1'b0;
      if ((cmd.step && res_v && (cmd.direct || pend_v_r)) || cmd.flush) out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end
  end

  assign out_valid      = out_v_r;
  assign out_token      = out_r.token;
  assign out_char_value = out_r.chr;
  assign out_arg_one    = out_r.a1;
  assign out_arg_two    = out_r.a2;
  assign out_last       = out_last_r;

endmodule
`default_nettype wire

[verif/aet_checker.sv]
`timescale 1ns / 100ps
module aet_checker
  import aet_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_ready,
  input  wire logic [CHR_W-1:0] in_byte_in,
  input  wire logic             out_valid,
  input  wire logic             out_ready,
  input  wire logic [TOK_W-1:0] out_token,
  input  wire logic [CHR_W-1:0] out_char_value,
  input  wire logic [ARG_W-1:0] out_arg_one,
  input  wire logic [ARG_W-1:0] out_arg_two,
  input  wire logic             out_last,
  output int                    err_count,
  output int                    pend_count,
  output int                    seen_count
);

  localparam logic [7:0] ESC = 8'h1b;
  localparam int WORDS_PER_BYTE = 4;

  typedef enum logic [3:0] {
    P_IDLE, P_ESC, P_CSI, P_Q, P_LK_H, P_LK_PAREN, P_LK_Q7, P_LK_Q1H, P_LK_Q1L,
    P_NUM1, P_SEMI1, P_NUM2, P_SEMI2, P_NUM3, P_SWALLOW
  } parse_t;

  typedef struct packed {
    logic [TOK_W-1:0] token;
    logic [CHR_W-1:0] chr;
    logic [ARG_W-1:0] a1;
    logic [ARG_W-1:0] a2;
    logic             last;
  } tok_word_t;

  parse_t      pst;
  logic [7:0]  held [4];
  int          held_n;
  logic [15:0] num_a, num_b;
  logic [7:0]  pending_bytes [$];
  int          words_this_byte;
  tok_word_t   expected_words [$];

  task automatic put(logic [TOK_W-1:0] t, logic [7:0] c, logic [15:0] a1, logic [15:0] a2);
    tok_word_t w;
    if (words_this_byte < WORDS_PER_BYTE) begin
      w = '{t, c, a1, a2, 1'b0};
      expected_words.push_back(w);
      words_this_byte++;
    end
  endtask

  function automatic logic [15:0] add_digit(logic [15:0] v, logic [7:0] b);
    int unsigned t;
    t = v;
    t = t * 10 + (b - 8'h30);
    return (t > 65535) ? 16'hffff : t[15:0];
  endfunction

  function automatic bit is_num(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic int pat_len(parse_t s);
    case (s)
      P_LK_H:  return 3;
      P_LK_Q7: return 2;
      default: return 4;
    endcase
  endfunction

  function automatic logic [7:0] pat_byte(parse_t s, int i);
    logic [7:0] p [4];
    case (s)
      P_LK_H:     p = '{ESC, "[", "J", 8'h00};
      P_LK_PAREN: p = '{"B", ESC, ")", "0"};
      P_LK_Q7:    p = '{"7", "h", 8'h00, 8'h00};
      P_LK_Q1H:   p = '{"1", "h", ESC, "="};
      default:    p = '{"1", "l", ESC, ">"};
    endcase
    return p[i];
  endfunction

  // lookahead: keep matching, or give up and push held bytes back for reparse
  task automatic lookahead(logic [7:0] b);
    int len;
    int first;
    logic [7:0] back [$];
    if (pst == P_LK_Q1H && held_n == 1 && b == "l") pst = P_LK_Q1L;
    len = pat_len(pst);
    if (held_n < len && held_n < 4 && b == pat_byte(pst, held_n)) begin
      held[held_n] = b;
      held_n++;
      if (held_n == len) begin
        put(pst == P_LK_H ? TOK_CL : TOK_ER, 0, 0, 0);
        pst = P_IDLE;
        held_n = 0;
      end
      return;
    end
    first = 0;
    if (pst == P_LK_H) put(TOK_HM, 0, 0, 0);
    else if (pst == P_LK_PAREN) put(TOK_PLAIN, "(", 0, 0);
    else begin
      put(TOK_PLAIN, held_n > 0 ? held[0] : 8'h00, 0, 0);
      first = 1;
    end
    for (int i = first; i < held_n; i++) back.push_back(held[i]);
    back.push_back(b);
    pst = P_IDLE;
    held_n = 0;
    pending_bytes = {back, pending_bytes};
  endtask

  task automatic parse_byte(logic [7:0] b);
    parse_t s;
    s = pst;
    if (s >= P_LK_H && s <= P_LK_Q1L) begin
      lookahead(b);
      return;
    end
    pst = P_IDLE;
    case (s)
      P_IDLE: begin
        if (b == ESC) pst = P_ESC;
        else if (b == 8'h0f) put(TOK_ER, 0, 0, 0);
        else if (b == 8'h08) put(TOK_BS, 0, 0, 0);
        else if (b == 8'h0a) put(TOK_LF, 0, 0, 0);
        else if (b == 8'h0d) put(TOK_CR, 0, 0, 0);
        else if (b == 8'h09) put(TOK_TA, 0, 0, 0);
        else put(TOK_PLAIN, b, 0, 0);
      end
      P_ESC: begin
        if (b == "[") pst = P_CSI;
        else if (b == "(") begin pst = P_LK_PAREN; held_n = 0; end
        else if (b == "7") put(TOK_SC, 0, 0, 0);
        else if (b == "8") put(TOK_RC, 0, 0, 0);
        else if (b == "M") put(TOK_SR, 0, 0, 0);
        else put(TOK_PLAIN, b, 0, 0);
      end
      P_CSI: begin
        if (b == "A") put(TOK_UP, 0, 0, 0);
        else if (b == "H") begin pst = P_LK_H; held_n = 0; end
        else if (b == "K") put(TOK_CE, 0, 0, 0);
        else if (b == "m") put(TOK_SE, 0, 0, 0);
        else if (b == "?") pst = P_Q;
        else if (is_num(b)) begin num_a = add_digit(0, b); pst = P_NUM1; end
        else put(TOK_PLAIN, "[", 0, 0);
      end
      P_Q: begin
        if (b == "7" || b == "1") begin
          held[0] = b;
          held_n = 1;
          pst = (b == "7") ? P_LK_Q7 : P_LK_Q1H;
        end else put(TOK_PLAIN, b, 0, 0);
      end
      P_NUM1: begin
        if (is_num(b)) begin num_a = add_digit(num_a, b); pst = P_NUM1; end
        else if (b == "m") put(num_a == 7 ? TOK_SO : TOK_ER, 0, 0, 0);
        else if (b == "A") put(TOK_NU, 0, num_a, 0);
        else if (b == "B") put(TOK_ND, 0, num_a, 0);
        else if (b == "C") put(TOK_NR, 0, num_a, 0);
        else if (b == "D") put(TOK_NL, 0, num_a, 0);
        else if (b == "K") put(num_a == 1 ? TOK_CB : TOK_ER, 0, 0, 0);
        else if (b == ";") pst = P_SEMI1;
        else put(TOK_PLAIN, "[", 0, 0);
      end
      P_SEMI1: begin
        if (is_num(b)) begin num_b = add_digit(0, b); pst = P_NUM2; end
        else put(TOK_PLAIN, "[", 0, 0);
      end
      P_NUM2: begin
        if (is_num(b)) begin num_b = add_digit(num_b, b); pst = P_NUM2; end
        else if (b == "H") put(TOK_CM, 0, num_a, num_b);
        else if (b == "r") put(TOK_CH, 0, num_a, num_b);
        else if (b == ";") pst = P_SEMI2;
        else put(TOK_PLAIN, "[", 0, 0);
      end
      P_SEMI2: begin
        if (is_num(b)) pst = P_NUM3;
        else put(TOK_PLAIN, "[", 0, 0);
      end
      P_NUM3: begin
        if (is_num(b)) pst = P_NUM3;
        else if (b == "m") pst = P_SWALLOW;
        else put(TOK_PLAIN, "[", 0, 0);
      end
      default: put(TOK_ER, 0, 0, 0);
    endcase
  endtask

  // one accepted byte: drain the reparse queue, then flag the last word
  task automatic tokenize(logic [7:0] b);
    logic [7:0] nb;
    words_this_byte = 0;
    pending_bytes.push_back(b);
    while (pending_bytes.size() > 0) begin
      nb = pending_bytes.pop_front();
      parse_byte(nb);
    end
    if (words_this_byte > 0) expected_words[$].last = 1'b1;
  endtask

  always @(posedge clk) begin
    tok_word_t w;
    if (!rst_n) begin
      pst = P_IDLE;
      held_n = 0;
      num_a = 0;
      num_b = 0;
      pending_bytes.delete();
      expected_words.delete();
      err_count <= 0;
      seen_count <= 0;
    end else begin
      if (in_valid && in_ready) tokenize(in_byte_in);
      if (out_valid && out_ready) begin
        seen_count <= seen_count + 1;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word tok=%0d chr=%02h a1=%0d a2=%0d last=%0b", $time,
                   out_token, out_char_value, out_arg_one, out_arg_two, out_last);
          err_count <= err_count + 1;
        end else begin
          w = expected_words.pop_front();
          if (w.token !== out_token || w.chr !== out_char_value || w.a1 !== out_arg_one ||
              w.a2 !== out_arg_two || w.last !== out_last) begin
            $display("%0t: mismatch expected tok=%0d chr=%02h a1=%0d a2=%0d last=%0b",
                     $time, w.token, w.chr, w.a1, w.a2, w.last);
            $display("%0t:          actual   tok=%0d chr=%02h a1=%0d a2=%0d last=%0b",
                     $time, out_token, out_char_value, out_arg_one, out_arg_two, out_last);
            err_count <= err_count + 1;
          end
        end
      end
    end
    pend_count <= expected_words.size();
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
module tb
  import aet_pkg::*;
();

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [CHR_W-1:0] in_byte_in = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [TOK_W-1:0] out_token;
  logic [CHR_W-1:0] out_char_value;
  logic [ARG_W-1:0] out_arg_one;
  logic [ARG_W-1:0] out_arg_two;
  logic             out_last;
  int               err_count, pend_count, seen_count;

  // terminal byte stream waiting to be sent
  logic [7:0] stream [$];
  int         seq_count;
  bit         calm;
  int         stall_left;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ansi_escape_tokenizer_core DUT (
    .clk, .rst_n, .in_valid, .in_ready, .in_byte_in, .out_valid, .out_ready,
    .out_token, .out_char_value, .out_arg_one, .out_arg_two, .out_last
  );

  aet_checker chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_byte_in, .out_valid, .out_ready,
    .out_token, .out_char_value, .out_arg_one, .out_arg_two, .out_last,
    .err_count, .pend_count, .seen_count
  );

  // hard stop well past the slowest legal run
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // sink side: random stalls, mostly short, some long, none started in calm stretches
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else out_ready <= 1'b1;
  end

  // flip between noisy and gap-free stretches
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) calm <= ~calm;
  end

  task automatic add_str(string s);
    foreach (s[i]) stream.push_back(s[i]);
  endtask

  function automatic string rand_num();
    case ($urandom_range(0, 7))
      0: return $sformatf("%0d", $urandom_range(0, 9));
      1: return $sformatf("%0d", $urandom_range(65530, 999999));
      2: return $sformatf("00%0d", $urandom_range(0, 20));
      default: return $sformatf("%0d", $urandom_range(0, 300));
    endcase
  endfunction

  // one sequence, mostly well-formed, with random content, sometimes broken
  task automatic add_random_seq();
    logic [7:0] q [$];
    string s;
    string csi_end;
    string cm_end;
    string esc_end;
    int cut;
    csi_end = "ABCDKm";
    cm_end  = "Hr";
    esc_end = "78M";
    case ($urandom_range(0, 21))
      0, 1: s = $sformatf("%c", $urandom_range(0, 255));
      2: s = $sformatf("%c", 8'h0f);
      3: s = "\010\012\015\011";
      4: s = "\033[A";
      5: s = "\033[H\033[J";
      6: s = "\033[H";
      7: s = "\033[K";
      8: s = "\033[m";
      9: s = "\033[?7h";
      10: s = "\033[?1h\033=";
      11: s = "\033[?1l\033>";
      12: s = $sformatf("\033[%s%c", rand_num(), csi_end[$urandom_range(0, 5)]);
      13: s = $sformatf("\033[%s;%s%c", rand_num(), rand_num(), cm_end[$urandom_range(0, 1)]);
      14: s = $sformatf("\033[%s;%s;%sm%c", rand_num(), rand_num(), rand_num(),
                        $urandom_range(0, 255));
      15: s = "\033(B\033)0";
      16: s = $sformatf("\033%c", esc_end[$urandom_range(0, 2)]);
      17: s = $sformatf("\033%c", $urandom_range(0, 255));
      18: s = $sformatf("\033[?%c", $urandom_range(0, 255));
      19: s = "\033[7m";
      20: s = "\033[1K";
      default: s = $sformatf("\033[%c", $urandom_range(0, 255));
    endcase
    foreach (s[i]) q.push_back(s[i]);
    // break roughly one sequence in six at a random byte
    if (q.size() > 1 && $urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, q.size() - 1);
      while (q.size() > cut) void'(q.pop_back());
      q.push_back($urandom_range(0, 255));
    end
    foreach (q[i]) stream.push_back(q[i]);
  endtask

  task automatic send_word(logic [7:0] b, bit first);
    int gap;
    gap = first ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_in <= b;
    // hold until the block takes it
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    int n_bytes;
    int waited;
    // directed: controls, byte extremes, every token, lookahead matches and misses
    stream.push_back(8'h00);
    add_str("\377\010\012\015\011\017A");
    add_str("\033[A\033[K\033[m\033[H\033[J\033[Hx\033[H\033[x");
    add_str("\033(B\033)0\033(B\033)1\033(q\0337\0338\033M\033q");
    add_str("\033[?7h\033[?7x\033[?1h\033=\033[?1l\033>\033[?1h\033x\033[?z");
    add_str("\033[12A\033[3B\033[99999C\033[0D\033[007m\033[9m\033[01K\033[2K");
    add_str("\033[5;65535H\033[1;24r\033[1;2;3mZ\033[4;x\033[4;5;x\033[4%");
    seq_count = 25;
    while (stream.size() < 270) begin
      add_random_seq();
      seq_count++;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    n_bytes = stream.size();
    for (int i = 0; i < n_bytes; i++) send_word(stream[i], i == 0);
    in_valid <= 1'b0;
    @(posedge clk);

    // drain outstanding words, then allow the replay latency to settle
    waited = 0;
    while (pend_count != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (30) @(posedge clk);

    $display("sent %0d bytes in %0d sequences; %0d tokens checked", n_bytes, seq_count,
             seen_count);
    if (err_count == 0 && pend_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d tokens missing", err_count, pend_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
